[rtl/pwmdc_pkg.sv]
// Shared types and constants for the PWM duty-cycle meter.
`timescale 1ns / 1ps

package pwmdc_pkg;

    // Capture timer width and derived result widths
    localparam int TIMER_WIDTH  = 16;
    localparam int DUTY_W       = 7;
    localparam int PROD_W       = TIMER_WIDTH + DUTY_W;
    localparam int STEP_W       = $clog2(DUTY_W);

    // Duty constants
    localparam logic [DUTY_W-1:0] DUTY_MAX      = DUTY_W'(100);
    localparam logic [DUTY_W-1:0] DUTY_LIMIT    = DUTY_W'(101);
    localparam logic [DUTY_W-1:0] THRESH_RESET  = DUTY_W'(40);

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // Job queue depth
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // One job handed from the capture front end to the duty engine
    typedef struct packed {
        logic                   fault;
        logic [TIMER_WIDTH-1:0] period;
        logic [TIMER_WIDTH-1:0] high;
    } t_job;

endpackage

[rtl/pwmdc_front.sv]
// Capture front end: tracks edge timestamps and issues period jobs.
`timescale 1ns / 1ps

module pwmdc_front
    import pwmdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_edge_rising,
    input  logic [TIMER_WIDTH-1:0] i_capture_time,
    input  logic                 i_capture_overflow,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    logic                   r_await;
    logic                   r_rise_seen;
    logic                   r_halted;
    logic [TIMER_WIDTH-1:0] r_first;
    logic [TIMER_WIDTH-1:0] r_fall;
    logic                   w_xfer;
    logic                   w_live;

    assign o_ready = ~i_q_full;
    assign w_xfer  = i_valid & o_ready;
    assign w_live  = w_xfer & ~r_halted;

    // A job goes out on overflow or on a period-ending rise
    assign o_push       = w_live & (i_capture_overflow | (i_edge_rising & r_await));
    assign o_job.fault  = i_capture_overflow;
    assign o_job.period = i_capture_overflow ? '0 : (i_capture_time - r_first);
    assign o_job.high   = i_capture_overflow ? '0 : (r_fall - r_first);

    // Edge bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await     <= 1'b0;
            r_rise_seen <= 1'b0;
            r_halted    <= 1'b0;
            r_first     <= '0;
            r_fall      <= '0;
        end else if (w_live) begin
            if (i_capture_overflow) begin
                r_halted <= 1'b1;
            end else if (!i_edge_rising) begin
                if (r_rise_seen) begin
                    r_fall <= i_capture_time;
                end
            end else begin
                r_rise_seen <= 1'b1;
                r_await     <= ~r_await;
                if (!r_await) begin
                    r_first <= i_capture_time;
                end
            end
        end
    end

endmodule

[rtl/pwmdc_queue.sv]
// Short job queue between the capture front end and the duty engine.
`timescale 1ns / 1ps

module pwmdc_queue
    import pwmdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/pwmdc_back.sv]
// Duty engine: saturation check, bit-serial divide and result register.
`timescale 1ns / 1ps

module pwmdc_back
    import pwmdc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [DUTY_W-1:0]      i_threshold,
    input  logic                   i_q_empty,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [TIMER_WIDTH-1:0] o_period_ticks,
    output logic [TIMER_WIDTH-1:0] o_high_ticks,
    output logic [DUTY_W-1:0]      o_duty_percent,
    output logic                   o_led_on,
    output logic                   o_bad_period,
    output logic                   o_halted_fault
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                 r_state;
    logic                   r_fault;
    logic [TIMER_WIDTH-1:0] r_per;
    logic [TIMER_WIDTH-1:0] r_hi;
    logic [PROD_W-1:0]      r_prod;
    logic [PROD_W-1:0]      r_lim;
    logic [PROD_W-1:0]      r_rem;
    logic [PROD_W-1:0]      r_div;
    logic [DUTY_W-1:0]      r_quo;
    logic [STEP_W-1:0]      r_step;
    logic                   r_bad;
    logic                   r_led_state;
    logic                   w_fit;
    logic                   w_led;
    logic                   w_out_free;

    assign o_pop      = (r_state == ST_IDLE) & ~i_q_empty;
    assign w_fit      = (r_rem >= r_div);
    assign w_led      = r_fault ? r_led_state : (r_quo > i_threshold);
    assign w_out_free = ~o_valid | i_ready;

    // Sequencer, datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_led_state <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            // ST_OUT reloads the result register itself
            if (o_valid && i_ready && (r_state != ST_OUT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_fault <= i_job.fault;
                        r_per   <= i_job.period;
                        r_hi    <= i_job.high;
                        r_quo   <= '0;
                        r_bad   <= 1'b0;
                        r_state <= i_job.fault ? ST_OUT : ST_MUL;
                    end
                end
                ST_MUL: begin
                    // hi*100 against per*101 tells whether the duty saturates
                    r_prod  <= PROD_W'(r_hi) * PROD_W'(DUTY_MAX);
                    r_lim   <= PROD_W'(r_per) * PROD_W'(DUTY_LIMIT);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_per == '0) begin
                        r_quo   <= '0;
                        r_bad   <= 1'b1;
                        r_state <= ST_OUT;
                    end else if (r_prod >= r_lim) begin
                        r_quo   <= DUTY_MAX;
                        r_bad   <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        // Quotient below 101 fits in DUTY_W bits
                        r_rem   <= r_prod;
                        r_div   <= PROD_W'(r_per) << (DUTY_W - 1);
                        r_step  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // Restoring divide, one quotient bit a cycle
                    if (w_fit) begin
                        r_rem <= r_rem - r_div;
                    end
                    r_quo  <= {r_quo[DUTY_W-2:0], w_fit};
                    r_div  <= r_div >> 1;
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DUTY_W - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        o_valid        <= 1'b1;
                        o_period_ticks <= r_per;
                        o_high_ticks   <= r_hi;
                        o_duty_percent <= r_quo;
                        o_led_on       <= w_led;
                        o_bad_period   <= r_bad;
                        o_halted_fault <= r_fault;
                        r_led_state    <= w_led;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/pwm_duty_cycle_meter.sv]
// Top level of the PWM duty-cycle meter: stream ports, threshold register.
`timescale 1ns / 1ps
// A period-ending rise or an overflow gives a result at the output; fault
// results skip the multiply, check and divide, and zero or saturated periods
// skip the divide. Other edges give no result.
// Edges with no result are taken every cycle while the two-entry job queue
// has room; the duty engine takes a new job only once it has finished the
// last one, using its 7-step serial divider. Reset (synchronous, active low)
// clears edge state, halt, indicator and queue, and sets the threshold to 40.

module pwm_duty_cycle_meter
    import pwmdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write: duty_threshold
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [DUTY_W-1:0]    i_cfg_data,
    // Capture stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] capture_time
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] edge_rising, [1] capture_overflow
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] period_ticks, [31:16] high_ticks, [38:32] duty_percent,
    // [39] led_on, [40] bad_period, [47:41] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser   // [0] halted_fault
);

    logic [DUTY_W-1:0]      r_threshold;
    logic                   w_push;
    t_job                   w_push_job;
    logic                   w_full;
    logic                   w_pop;
    logic                   w_empty;
    t_job                   w_head_job;
    logic [TIMER_WIDTH-1:0] w_period;
    logic [TIMER_WIDTH-1:0] w_high;
    logic [DUTY_W-1:0]      w_duty;
    logic                   w_led;
    logic                   w_bad;
    logic                   w_fault;

    // Threshold register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    pwmdc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (s_axis_tvalid),
        .o_ready            (s_axis_tready),
        .i_edge_rising      (s_axis_tuser[0]),
        .i_capture_time     (s_axis_tdata[TIMER_WIDTH-1:0]),
        .i_capture_overflow (s_axis_tuser[1]),
        .i_q_full           (w_full),
        .o_push             (w_push),
        .o_job              (w_push_job)
    );

    pwmdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    pwmdc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold    (r_threshold),
        .i_q_empty      (w_empty),
        .i_job          (w_head_job),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_period_ticks (w_period),
        .o_high_ticks   (w_high),
        .o_duty_percent (w_duty),
        .o_led_on       (w_led),
        .o_bad_period   (w_bad),
        .o_halted_fault (w_fault)
    );

    // Result packing
    assign m_axis_tdata = {7'b0, w_bad, w_led, w_duty, w_high, w_period};
    assign m_axis_tuser = w_fault;

endmodule

[rtl/pwmdc_checker.sv]
// Port-level checks for the PWM duty-cycle meter, bound to the top level.
`timescale 1ns / 1ps

module pwmdc_checker
    import pwmdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [M_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Duty never exceeds full scale
    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[38:32] <= DUTY_MAX)
        else $error("duty above 100 percent");

    // Fault result carries no measurement
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[38:0] == '0 && !m_axis_tdata[40])
        else $error("fault result carries data");

    // No valid result directly follows the fault transfer
    a_fault_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=> !m_axis_tvalid)
        else $error("result after halt");

    // Zero period: duty 0 and indicator off
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata[40] &&
            m_axis_tdata[38:32] != DUTY_MAX |->
            m_axis_tdata[38:32] == '0 && !m_axis_tdata[39])
        else $error("bad period with wrong duty");

endmodule

bind pwm_duty_cycle_meter pwmdc_checker u_pwmdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
